>>> hdl/c_punctuator_scanner_unit_defines.svh
// Assertion macros shared by the checker of the punctuator scanner.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef C_PUNCTUATOR_SCANNER_UNIT_DEFINES_SVH
`define C_PUNCTUATOR_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cpsu_pkg.sv
// Package of the punctuator scanner: beat types and token kind codes.
// Depends on nothing; used by the scanner and its checker.
package cpsu_pkg;

    localparam int COLUMN_BITS = 16;
    localparam int KIND_BITS   = 6;

    localparam logic [KIND_BITS-1:0] K_INC          = 6'd0;
    localparam logic [KIND_BITS-1:0] K_PLUS_ASSIGN  = 6'd1;
    localparam logic [KIND_BITS-1:0] K_PLUS         = 6'd2;
    localparam logic [KIND_BITS-1:0] K_DEC          = 6'd3;
    localparam logic [KIND_BITS-1:0] K_MINUS_ASSIGN = 6'd4;
    localparam logic [KIND_BITS-1:0] K_ARROW        = 6'd5;
    localparam logic [KIND_BITS-1:0] K_MINUS        = 6'd6;
    localparam logic [KIND_BITS-1:0] K_STAR_ASSIGN  = 6'd7;
    localparam logic [KIND_BITS-1:0] K_STAR         = 6'd8;
    localparam logic [KIND_BITS-1:0] K_SLASH_ASSIGN = 6'd9;
    localparam logic [KIND_BITS-1:0] K_SLASH        = 6'd10;
    localparam logic [KIND_BITS-1:0] K_PCT_ASSIGN   = 6'd11;
    localparam logic [KIND_BITS-1:0] K_HASHHASH     = 6'd12;
    localparam logic [KIND_BITS-1:0] K_HASH         = 6'd13;
    localparam logic [KIND_BITS-1:0] K_PERCENT      = 6'd14;
    localparam logic [KIND_BITS-1:0] K_RBRACE       = 6'd15;
    localparam logic [KIND_BITS-1:0] K_EQ           = 6'd16;
    localparam logic [KIND_BITS-1:0] K_ASSIGN       = 6'd17;
    localparam logic [KIND_BITS-1:0] K_NE           = 6'd18;
    localparam logic [KIND_BITS-1:0] K_NOT          = 6'd19;
    localparam logic [KIND_BITS-1:0] K_SHL_ASSIGN   = 6'd20;
    localparam logic [KIND_BITS-1:0] K_SHL          = 6'd21;
    localparam logic [KIND_BITS-1:0] K_LE           = 6'd22;
    localparam logic [KIND_BITS-1:0] K_LBRACKET     = 6'd23;
    localparam logic [KIND_BITS-1:0] K_LT           = 6'd24;
    localparam logic [KIND_BITS-1:0] K_LBRACE       = 6'd25;
    localparam logic [KIND_BITS-1:0] K_SHR_ASSIGN   = 6'd26;
    localparam logic [KIND_BITS-1:0] K_SHR          = 6'd27;
    localparam logic [KIND_BITS-1:0] K_GE           = 6'd28;
    localparam logic [KIND_BITS-1:0] K_GT           = 6'd29;
    localparam logic [KIND_BITS-1:0] K_ANDAND       = 6'd30;
    localparam logic [KIND_BITS-1:0] K_AMP_ASSIGN   = 6'd31;
    localparam logic [KIND_BITS-1:0] K_AMP          = 6'd32;
    localparam logic [KIND_BITS-1:0] K_OROR         = 6'd33;
    localparam logic [KIND_BITS-1:0] K_PIPE_ASSIGN  = 6'd34;
    localparam logic [KIND_BITS-1:0] K_PIPE         = 6'd35;
    localparam logic [KIND_BITS-1:0] K_CARET_ASSIGN = 6'd36;
    localparam logic [KIND_BITS-1:0] K_CARET        = 6'd37;
    localparam logic [KIND_BITS-1:0] K_TILDE        = 6'd38;
    localparam logic [KIND_BITS-1:0] K_QUESTION     = 6'd39;
    localparam logic [KIND_BITS-1:0] K_RBRACKET     = 6'd40;
    localparam logic [KIND_BITS-1:0] K_COLON        = 6'd41;
    localparam logic [KIND_BITS-1:0] K_SEMI         = 6'd42;
    localparam logic [KIND_BITS-1:0] K_COMMA        = 6'd43;
    localparam logic [KIND_BITS-1:0] K_LPAREN       = 6'd44;
    localparam logic [KIND_BITS-1:0] K_RPAREN       = 6'd45;
    localparam logic [KIND_BITS-1:0] K_ELLIPSIS     = 6'd46;
    localparam logic [KIND_BITS-1:0] K_DOT          = 6'd47;
    localparam logic [KIND_BITS-1:0] K_DOTNUM       = 6'd48;
    localparam logic [KIND_BITS-1:0] K_BAD          = 6'd49;

    typedef struct packed {
        logic [7:0]             ch;
        logic [COLUMN_BITS-1:0] col;
        logic                   flush;
    } t_in_beat;

    typedef struct packed {
        logic [KIND_BITS-1:0]   token_kind;
        logic [COLUMN_BITS-1:0] tok_col;
        logic                   is_last;
    } t_out_beat;

endpackage

>>> hdl/c_punctuator_scanner_unit.sv
// Top level of the C punctuator scanner: input register, longest-match logic, result buffer.
// Depends on cpsu_pkg for the beat types and the token kind codes.

// Takes one character beat per cycle while the result buffer can take its results, and
// returns punctuator tokens by longest match, with optional digraphs. A beat waits in the
// input register until the result buffer is free, and its results are then registered
// into that buffer. A beat yields zero to three results, which leave the three-entry
// result buffer one per cycle while the receiver is ready, so a beat with more than one
// result holds up the next beat; with one result or none per beat and a ready receiver
// the rate is one beat per cycle. The buffer is refilled in the same cycle in which its last result is taken.
module c_punctuator_scanner_unit
    import cpsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam logic [4:0] P_IDLE    = 5'd0;
    localparam logic [4:0] P_PLUS    = 5'd1;
    localparam logic [4:0] P_MINUS   = 5'd2;
    localparam logic [4:0] P_STAR    = 5'd3;
    localparam logic [4:0] P_SLASH   = 5'd4;
    localparam logic [4:0] P_PCT     = 5'd5;
    localparam logic [4:0] P_PCOL    = 5'd6;
    localparam logic [4:0] P_PCOLPCT = 5'd7;
    localparam logic [4:0] P_EQ      = 5'd8;
    localparam logic [4:0] P_BANG    = 5'd9;
    localparam logic [4:0] P_LT      = 5'd10;
    localparam logic [4:0] P_LTLT    = 5'd11;
    localparam logic [4:0] P_GT      = 5'd12;
    localparam logic [4:0] P_GTGT    = 5'd13;
    localparam logic [4:0] P_AMP     = 5'd14;
    localparam logic [4:0] P_PIPE    = 5'd15;
    localparam logic [4:0] P_CARET   = 5'd16;
    localparam logic [4:0] P_COLON   = 5'd17;
    localparam logic [4:0] P_HASH    = 5'd18;
    localparam logic [4:0] P_DOT     = 5'd19;
    localparam logic [4:0] P_DOTDOT  = 5'd20;

    typedef struct packed {
        logic                 done;
        logic                 grow;
        logic [KIND_BITS-1:0] kind;
        logic [4:0]           nxt;
    } t_ext;

    typedef struct packed {
        logic                 is_prefix;
        logic [4:0]           prefix;
        logic [KIND_BITS-1:0] kind;
    } t_start;

    function automatic t_ext extend(input logic [4:0] p, input logic [7:0] c, input logic dg);
        t_ext e;
        e = '{done: 1'b0, grow: 1'b0, kind: K_BAD, nxt: P_IDLE};
        unique case (p)
            P_PLUS: begin
                if (c == "+") e = '{1'b1, 1'b0, K_INC, P_IDLE};
                else if (c == "=") e = '{1'b1, 1'b0, K_PLUS_ASSIGN, P_IDLE};
            end
            P_MINUS: begin
                if (c == "-") e = '{1'b1, 1'b0, K_DEC, P_IDLE};
                else if (c == "=") e = '{1'b1, 1'b0, K_MINUS_ASSIGN, P_IDLE};
                else if (c == ">") e = '{1'b1, 1'b0, K_ARROW, P_IDLE};
            end
            P_STAR:  if (c == "=") e = '{1'b1, 1'b0, K_STAR_ASSIGN, P_IDLE};
            P_SLASH: if (c == "=") e = '{1'b1, 1'b0, K_SLASH_ASSIGN, P_IDLE};
            P_EQ:    if (c == "=") e = '{1'b1, 1'b0, K_EQ, P_IDLE};
            P_BANG:  if (c == "=") e = '{1'b1, 1'b0, K_NE, P_IDLE};
            P_CARET: if (c == "=") e = '{1'b1, 1'b0, K_CARET_ASSIGN, P_IDLE};
            P_PCT: begin
                if (c == "=") e = '{1'b1, 1'b0, K_PCT_ASSIGN, P_IDLE};
                else if (c == ":" && dg) e = '{1'b0, 1'b1, K_BAD, P_PCOL};
                else if (c == ">" && dg) e = '{1'b1, 1'b0, K_RBRACE, P_IDLE};
            end
            P_PCOL:    if (c == "%") e = '{1'b0, 1'b1, K_BAD, P_PCOLPCT};
            P_PCOLPCT: if (c == ":") e = '{1'b1, 1'b0, K_HASHHASH, P_IDLE};
            P_LT: begin
                if (c == "<") e = '{1'b0, 1'b1, K_BAD, P_LTLT};
                else if (c == "=") e = '{1'b1, 1'b0, K_LE, P_IDLE};
                else if (c == ":" && dg) e = '{1'b1, 1'b0, K_LBRACKET, P_IDLE};
                else if (c == "%" && dg) e = '{1'b1, 1'b0, K_LBRACE, P_IDLE};
            end
            P_LTLT: if (c == "=") e = '{1'b1, 1'b0, K_SHL_ASSIGN, P_IDLE};
            P_GT: begin
                if (c == ">") e = '{1'b0, 1'b1, K_BAD, P_GTGT};
                else if (c == "=") e = '{1'b1, 1'b0, K_GE, P_IDLE};
            end
            P_GTGT: if (c == "=") e = '{1'b1, 1'b0, K_SHR_ASSIGN, P_IDLE};
            P_AMP: begin
                if (c == "&") e = '{1'b1, 1'b0, K_ANDAND, P_IDLE};
                else if (c == "=") e = '{1'b1, 1'b0, K_AMP_ASSIGN, P_IDLE};
            end
            P_PIPE: begin
                if (c == "|") e = '{1'b1, 1'b0, K_OROR, P_IDLE};
                else if (c == "=") e = '{1'b1, 1'b0, K_PIPE_ASSIGN, P_IDLE};
            end
            P_COLON: if (c == ">" && dg) e = '{1'b1, 1'b0, K_RBRACKET, P_IDLE};
            P_HASH:  if (c == "#") e = '{1'b1, 1'b0, K_HASHHASH, P_IDLE};
            P_DOT: begin
                if (c == ".") e = '{1'b0, 1'b1, K_BAD, P_DOTDOT};
                else if (c >= "0" && c <= "9") e = '{1'b1, 1'b0, K_DOTNUM, P_IDLE};
            end
            P_DOTDOT: if (c == ".") e = '{1'b1, 1'b0, K_ELLIPSIS, P_IDLE};
            default: e = '{done: 1'b0, grow: 1'b0, kind: K_BAD, nxt: P_IDLE};
        endcase
        return e;
    endfunction

    function automatic logic [KIND_BITS-1:0] lone_kind(input logic [4:0] p);
        logic [KIND_BITS-1:0] k;
        unique case (p)
            P_PLUS:    k = K_PLUS;
            P_MINUS:   k = K_MINUS;
            P_STAR:    k = K_STAR;
            P_SLASH:   k = K_SLASH;
            P_PCT:     k = K_PERCENT;
            P_PCOL:    k = K_HASH;
            P_PCOLPCT: k = K_HASH;
            P_EQ:      k = K_ASSIGN;
            P_BANG:    k = K_NOT;
            P_LT:      k = K_LT;
            P_LTLT:    k = K_SHL;
            P_GT:      k = K_GT;
            P_GTGT:    k = K_SHR;
            P_AMP:     k = K_AMP;
            P_PIPE:    k = K_PIPE;
            P_CARET:   k = K_CARET;
            P_COLON:   k = K_COLON;
            P_HASH:    k = K_HASH;
            P_DOT:     k = K_DOT;
            P_DOTDOT:  k = K_DOT;
            default:   k = K_BAD;
        endcase
        return k;
    endfunction

    function automatic t_start start_of(input logic [7:0] c);
        t_start s;
        s = '{is_prefix: 1'b1, prefix: P_IDLE, kind: K_BAD};
        unique case (c)
            "+": s.prefix = P_PLUS;
            "-": s.prefix = P_MINUS;
            "*": s.prefix = P_STAR;
            "/": s.prefix = P_SLASH;
            "%": s.prefix = P_PCT;
            "=": s.prefix = P_EQ;
            "!": s.prefix = P_BANG;
            "<": s.prefix = P_LT;
            ">": s.prefix = P_GT;
            "&": s.prefix = P_AMP;
            "|": s.prefix = P_PIPE;
            "^": s.prefix = P_CARET;
            ":": s.prefix = P_COLON;
            "#": s.prefix = P_HASH;
            ".": s.prefix = P_DOT;
            "~": s = '{1'b0, P_IDLE, K_TILDE};
            "?": s = '{1'b0, P_IDLE, K_QUESTION};
            ";": s = '{1'b0, P_IDLE, K_SEMI};
            ",": s = '{1'b0, P_IDLE, K_COMMA};
            "(": s = '{1'b0, P_IDLE, K_LPAREN};
            ")": s = '{1'b0, P_IDLE, K_RPAREN};
            "[": s = '{1'b0, P_IDLE, K_LBRACKET};
            "]": s = '{1'b0, P_IDLE, K_RBRACKET};
            "{": s = '{1'b0, P_IDLE, K_LBRACE};
            "}": s = '{1'b0, P_IDLE, K_RBRACE};
            default: s = '{1'b0, P_IDLE, K_BAD};
        endcase
        return s;
    endfunction

    logic                   r_dg;
    logic                   r_in_valid;
    t_in_beat               r_in;
    logic [4:0]             r_prefix;
    logic [COLUMN_BITS-1:0] r_pcol;
    t_out_beat              r_res [3];
    logic [1:0]             r_rem;
    logic [1:0]             r_idx;

    logic                   buf_free;
    logic                   commit;
    logic [4:0]             n_prefix;
    logic [COLUMN_BITS-1:0] n_pcol;
    t_out_beat              n_res [3];
    logic [1:0]             n_cnt;

    logic                   va, vb, vc;
    logic [KIND_BITS-1:0]   ka, kb, kc;
    logic [COLUMN_BITS-1:0] ca, cb, cc;
    logic [4:0]             p1;
    logic [COLUMN_BITS-1:0] pc1;
    logic                   p1_live;
    logic                   do_start;
    t_ext                   ext;
    t_start                 st;
    t_out_beat              sa, sb, sc;

    assign buf_free   = (r_rem == 2'd0) || ((r_rem == 2'd1) && i_out_ready);
    assign commit     = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || commit;

    assign o_out_valid = (r_rem != 2'd0);
    assign o_out_data  = r_res[r_idx];

    always_comb begin
        va = 1'b0; vb = 1'b0; vc = 1'b0;
        ka = K_BAD; kb = K_BAD; kc = K_BAD;
        ca = r_pcol; cb = r_pcol; cc = r_in.col;
        p1 = r_prefix;
        pc1 = r_pcol;
        do_start = 1'b0;
        n_prefix = P_IDLE;
        n_pcol = r_pcol;
        p1_live = 1'b0;
        ext = extend(r_prefix, r_in.ch, r_dg);
        st = start_of(r_in.ch);

        if (r_in.flush) begin
            if (r_prefix == P_PCOLPCT) begin
                va = 1'b1; ka = K_HASH;
                vb = 1'b1; kb = K_PERCENT; cb = r_pcol + COLUMN_BITS'(2);
            end else if (r_prefix == P_DOTDOT) begin
                va = 1'b1; ka = K_DOT;
                vb = 1'b1; kb = K_DOT; cb = r_pcol + COLUMN_BITS'(1);
            end else if (r_prefix != P_IDLE && r_prefix <= P_DOTDOT) begin
                va = 1'b1; ka = lone_kind(r_prefix);
            end
        end else begin
            if (r_prefix == P_PCOLPCT && r_in.ch != ":") begin
                va = 1'b1; ka = K_HASH;
                p1 = P_PCT; pc1 = r_pcol + COLUMN_BITS'(2);
            end else if (r_prefix == P_DOTDOT && r_in.ch != ".") begin
                va = 1'b1; ka = K_DOT;
                p1 = P_DOT; pc1 = r_pcol + COLUMN_BITS'(1);
            end
            ext = extend(p1, r_in.ch, r_dg);
            p1_live = (p1 != P_IDLE) && (p1 <= P_DOTDOT);
            n_pcol = pc1;
            if (!p1_live) begin
                do_start = 1'b1;
            end else if (ext.done) begin
                vb = 1'b1; kb = ext.kind; cb = pc1;
            end else if (ext.grow) begin
                n_prefix = ext.nxt;
            end else begin
                vb = 1'b1; kb = lone_kind(p1); cb = pc1;
                do_start = 1'b1;
            end
            if (do_start) begin
                if (st.is_prefix) begin
                    n_prefix = st.prefix;
                    n_pcol = r_in.col;
                end else begin
                    vc = 1'b1; kc = st.kind;
                end
            end
        end

        sa = '{token_kind: ka, tok_col: ca, is_last: !vb && !vc};
        sb = '{token_kind: kb, tok_col: cb, is_last: !vc};
        sc = '{token_kind: kc, tok_col: cc, is_last: 1'b1};

        n_cnt = 2'(va) + 2'(vb) + 2'(vc);
        n_res[0] = va ? sa : (vb ? sb : sc);
        n_res[1] = (va && vb) ? sb : sc;
        n_res[2] = sc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dg       <= 1'b1;
            r_in_valid <= 1'b0;
            r_prefix   <= P_IDLE;
            r_pcol     <= '0;
            r_rem      <= 2'd0;
            r_idx      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_dg <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (commit) begin
                r_prefix <= n_prefix;
                r_pcol   <= n_pcol;
                r_rem    <= n_cnt;
                r_idx    <= 2'd0;
            end else if (o_out_valid && i_out_ready) begin
                r_rem <= r_rem - 2'd1;
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (commit) begin
            r_res <= n_res;
        end
    end

endmodule

>>> hdl/cpsu_checker.sv
// Port-level checker for the punctuator scanner, bound to the top level below.
// Depends on cpsu_pkg and on the assertion macros in the defines header.
`include "c_punctuator_scanner_unit_defines.svh"

module cpsu_checker
    import cpsu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_cfg_we,
    input logic      i_cfg_wdata,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);

    // A stalled result beat must hold its value.
    `CPSU_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result beat changed while stalled")

    // Results of one character beat leave without a gap until the last one.
    `CPSU_ASSERT_NEXT(a_group_cont, o_out_valid && i_out_ready && !o_out_data.is_last, o_out_valid, "result group broken before its last beat")

    `CPSU_ASSERT_NOW(a_kind_range, o_out_valid, o_out_data.token_kind <= K_BAD, "token kind out of range")

    // A dot before a digit hands the rest to number lexing, so nothing follows it.
    `CPSU_ASSERT_NOW(a_dotnum_last, o_out_valid && o_out_data.token_kind == K_DOTNUM, o_out_data.is_last, "result after a number-starting dot")

endmodule

bind c_punctuator_scanner_unit cpsu_checker u_cpsu_checker (.*);

>>> dv/c_punctuator_scanner_checker.sv
// Checker of the C punctuator scanner: watches both channels, predicts the tokens
// of each accepted character beat and compares every result beat in order.
// Depends on cpsu_pkg for the beat types and the token kind codes.
module c_punctuator_scanner_checker
    import cpsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        PF_IDLE, PF_PLUS, PF_MINUS, PF_STAR, PF_SLASH, PF_PCT, PF_PCOL, PF_PCOLPCT,
        PF_EQ, PF_BANG, PF_LT, PF_LTLT, PF_GT, PF_GTGT, PF_AMP, PF_PIPE, PF_CARET,
        PF_COLON, PF_HASH, PF_DOT, PF_DOTDOT
    } t_prefix;

    t_prefix                prefix_r = PF_IDLE;
    logic [COLUMN_BITS-1:0] prefix_col_r = '0;
    logic                   digraphs_r = 1'b1;

    t_out_beat token_q[$];
    t_out_beat beat_tokens[3];
    int        beat_token_n;
    int        mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [KIND_BITS-1:0] lone_token(input t_prefix p);
        case (p)
            PF_PLUS:                      return K_PLUS;
            PF_MINUS:                     return K_MINUS;
            PF_STAR:                      return K_STAR;
            PF_SLASH:                     return K_SLASH;
            PF_PCT:                       return K_PERCENT;
            PF_PCOL, PF_PCOLPCT, PF_HASH: return K_HASH;
            PF_EQ:                        return K_ASSIGN;
            PF_BANG:                      return K_NOT;
            PF_LT:                        return K_LT;
            PF_LTLT:                      return K_SHL;
            PF_GT:                        return K_GT;
            PF_GTGT:                      return K_SHR;
            PF_AMP:                       return K_AMP;
            PF_PIPE:                      return K_PIPE;
            PF_CARET:                     return K_CARET;
            PF_COLON:                     return K_COLON;
            default:                      return K_DOT;
        endcase
    endfunction

    task add_token(input logic [KIND_BITS-1:0] kind, input logic [COLUMN_BITS-1:0] col);
        if (beat_token_n < 3) begin
            beat_tokens[beat_token_n].token_kind = kind;
            beat_tokens[beat_token_n].tok_col    = col;
            beat_tokens[beat_token_n].is_last    = 1'b0;
            beat_token_n++;
        end
    endtask

    task finish_prefix(input logic [KIND_BITS-1:0] kind);
        add_token(kind, prefix_col_r);
        prefix_r = PF_IDLE;
    endtask

    task open_prefix(input logic [7:0] c, input logic [COLUMN_BITS-1:0] col);
        prefix_r = PF_IDLE;
        case (c)
            "+": prefix_r = PF_PLUS;
            "-": prefix_r = PF_MINUS;
            "*": prefix_r = PF_STAR;
            "/": prefix_r = PF_SLASH;
            "%": prefix_r = PF_PCT;
            "=": prefix_r = PF_EQ;
            "!": prefix_r = PF_BANG;
            "<": prefix_r = PF_LT;
            ">": prefix_r = PF_GT;
            "&": prefix_r = PF_AMP;
            "|": prefix_r = PF_PIPE;
            "^": prefix_r = PF_CARET;
            ":": prefix_r = PF_COLON;
            "#": prefix_r = PF_HASH;
            ".": prefix_r = PF_DOT;
            "~": add_token(K_TILDE, col);
            "?": add_token(K_QUESTION, col);
            ";": add_token(K_SEMI, col);
            ",": add_token(K_COMMA, col);
            "(": add_token(K_LPAREN, col);
            ")": add_token(K_RPAREN, col);
            "[": add_token(K_LBRACKET, col);
            "]": add_token(K_RBRACKET, col);
            "{": add_token(K_LBRACE, col);
            "}": add_token(K_RBRACE, col);
            default: add_token(K_BAD, col);
        endcase
        if (prefix_r != PF_IDLE) begin
            prefix_col_r = col;
        end
    endtask

    task split_prefix(input logic [7:0] c, input logic [COLUMN_BITS-1:0] col);
        finish_prefix(lone_token(prefix_r));
        open_prefix(c, col);
    endtask

    // A failed longer prefix (%:% or ..) gives up its first token and the rest
    // is scanned again, so the loop runs at most twice.
    task scan_char(input logic [7:0] c, input logic [COLUMN_BITS-1:0] col);
        logic rescan;
        logic [COLUMN_BITS-1:0] pc;
        rescan = 1'b1;
        while (rescan) begin
            rescan = 1'b0;
            pc = prefix_col_r;
            case (prefix_r)
                PF_IDLE: open_prefix(c, col);
                PF_PLUS: begin
                    if (c == "+") finish_prefix(K_INC);
                    else if (c == "=") finish_prefix(K_PLUS_ASSIGN);
                    else split_prefix(c, col);
                end
                PF_MINUS: begin
                    if (c == "-") finish_prefix(K_DEC);
                    else if (c == "=") finish_prefix(K_MINUS_ASSIGN);
                    else if (c == ">") finish_prefix(K_ARROW);
                    else split_prefix(c, col);
                end
                PF_STAR: if (c == "=") finish_prefix(K_STAR_ASSIGN); else split_prefix(c, col);
                PF_SLASH: if (c == "=") finish_prefix(K_SLASH_ASSIGN); else split_prefix(c, col);
                PF_EQ: if (c == "=") finish_prefix(K_EQ); else split_prefix(c, col);
                PF_BANG: if (c == "=") finish_prefix(K_NE); else split_prefix(c, col);
                PF_CARET: if (c == "=") finish_prefix(K_CARET_ASSIGN); else split_prefix(c, col);
                PF_PCT: begin
                    if (c == "=") finish_prefix(K_PCT_ASSIGN);
                    else if (c == ":" && digraphs_r) prefix_r = PF_PCOL;
                    else if (c == ">" && digraphs_r) finish_prefix(K_RBRACE);
                    else split_prefix(c, col);
                end
                PF_PCOL: if (c == "%") prefix_r = PF_PCOLPCT; else split_prefix(c, col);
                PF_PCOLPCT: begin
                    if (c == ":") begin
                        finish_prefix(K_HASHHASH);
                    end else begin
                        add_token(K_HASH, pc);
                        prefix_r     = PF_PCT;
                        prefix_col_r = pc + COLUMN_BITS'(2);
                        rescan       = 1'b1;
                    end
                end
                PF_LT: begin
                    if (c == "<") prefix_r = PF_LTLT;
                    else if (c == "=") finish_prefix(K_LE);
                    else if (c == ":" && digraphs_r) finish_prefix(K_LBRACKET);
                    else if (c == "%" && digraphs_r) finish_prefix(K_LBRACE);
                    else split_prefix(c, col);
                end
                PF_LTLT: if (c == "=") finish_prefix(K_SHL_ASSIGN); else split_prefix(c, col);
                PF_GT: begin
                    if (c == ">") prefix_r = PF_GTGT;
                    else if (c == "=") finish_prefix(K_GE);
                    else split_prefix(c, col);
                end
                PF_GTGT: if (c == "=") finish_prefix(K_SHR_ASSIGN); else split_prefix(c, col);
                PF_AMP: begin
                    if (c == "&") finish_prefix(K_ANDAND);
                    else if (c == "=") finish_prefix(K_AMP_ASSIGN);
                    else split_prefix(c, col);
                end
                PF_PIPE: begin
                    if (c == "|") finish_prefix(K_OROR);
                    else if (c == "=") finish_prefix(K_PIPE_ASSIGN);
                    else split_prefix(c, col);
                end
                PF_COLON: begin
                    if (c == ">" && digraphs_r) finish_prefix(K_RBRACKET);
                    else split_prefix(c, col);
                end
                PF_HASH: if (c == "#") finish_prefix(K_HASHHASH); else split_prefix(c, col);
                PF_DOT: begin
                    if (c == ".") prefix_r = PF_DOTDOT;
                    else if (c >= "0" && c <= "9") finish_prefix(K_DOTNUM);
                    else split_prefix(c, col);
                end
                PF_DOTDOT: begin
                    if (c == ".") begin
                        finish_prefix(K_ELLIPSIS);
                    end else begin
                        add_token(K_DOT, pc);
                        prefix_r     = PF_DOT;
                        prefix_col_r = pc + COLUMN_BITS'(1);
                        rescan       = 1'b1;
                    end
                end
                default: open_prefix(c, col);
            endcase
        end
    endtask

    task flush_prefix();
        case (prefix_r)
            PF_IDLE: ;
            PF_PCOLPCT: begin
                add_token(K_HASH, prefix_col_r);
                add_token(K_PERCENT, prefix_col_r + COLUMN_BITS'(2));
            end
            PF_DOTDOT: begin
                add_token(K_DOT, prefix_col_r);
                add_token(K_DOT, prefix_col_r + COLUMN_BITS'(1));
            end
            default: add_token(lone_token(prefix_r), prefix_col_r);
        endcase
        prefix_r = PF_IDLE;
    endtask

    task compare_token(input t_out_beat got);
        t_out_beat want;
        if (token_q.size() == 0) begin
            $error("token beat with nothing expected: token_kind %0d tok_col %0d is_last %0b",
                   got.token_kind, got.tok_col, got.is_last);
            mismatches++;
        end else begin
            want = token_q.pop_front();
            if (got.token_kind !== want.token_kind) begin
                $error("token_kind: expected %0d, actual %0d", want.token_kind, got.token_kind);
                mismatches++;
            end
            if (got.tok_col !== want.tok_col) begin
                $error("tok_col: expected %0d, actual %0d", want.tok_col, got.tok_col);
                mismatches++;
            end
            if (got.is_last !== want.is_last) begin
                $error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            prefix_r     = PF_IDLE;
            prefix_col_r = '0;
            digraphs_r   = 1'b1;
            token_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_token(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                beat_token_n = 0;
                if (i_in_data.flush) flush_prefix();
                else scan_char(i_in_data.ch, i_in_data.col);
                for (int k = 0; k < beat_token_n; k++) begin
                    beat_tokens[k].is_last = (k == beat_token_n - 1);
                    token_q.push_back(beat_tokens[k]);
                end
            end
            if (i_cfg_we) begin
                digraphs_r = i_cfg_wdata;
            end
        end
        o_outstanding <= token_q.size();
    end

endmodule

>>> dv/tb.sv
// Top of the punctuator scanner testbench: clock, reset, character stimulus, random
// idling on both channels, register writes between phases, and the verdict.
// Depends on cpsu_pkg, c_punctuator_scanner_unit and c_punctuator_scanner_checker.
module tb
    import cpsu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_BEATS    = 45;
    localparam int SPELLING_COUNT = 56;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    int fail_count;
    int outstanding;
    int beats_sent = 0;
    int idle_cycles = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    bit rx_steady = 1'b0;
    bit tx_gaps = 1'b1;
    logic [COLUMN_BITS-1:0] col_cursor = '0;

    always #10 i_clk = ~i_clk;

    c_punctuator_scanner_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    c_punctuator_scanner_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_data    (o_out_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // The receiver counts out a requested hold-off by itself.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= rx_steady || ($urandom_range(0, 99) >= 28);
        end
    end

    // Only result beats that are still expected count as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready && outstanding != 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[c_punctuator_scanner_unit] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic string spelling(input int unsigned n);
        case (n)
            0: return "++";   1: return "+=";   2: return "+";    3: return "--";
            4: return "-=";   5: return "->";   6: return "-";    7: return "*=";
            8: return "*";    9: return "/=";   10: return "/";   11: return "%=";
            12: return "##";  13: return "#";   14: return "%";   15: return "}";
            16: return "==";  17: return "=";   18: return "!=";  19: return "!";
            20: return "<<="; 21: return "<<";  22: return "<=";  23: return "[";
            24: return "<";   25: return "{";   26: return ">>="; 27: return ">>";
            28: return ">=";  29: return ">";   30: return "&&";  31: return "&=";
            32: return "&";   33: return "||";  34: return "|=";  35: return "|";
            36: return "^=";  37: return "^";   38: return "~";   39: return "?";
            40: return "]";   41: return ":";   42: return ";";   43: return ",";
            44: return "(";   45: return ")";   46: return "..."; 47: return ".";
            48: return ".7";  49: return "<:";  50: return ":>";  51: return "<%";
            52: return "%>";  53: return "%:";  54: return "%:%:";
            default: return "..";
        endcase
    endfunction

    // Called at a rising edge; returns at the edge at which the beat is taken.
    task automatic send_beat(input t_in_beat b);
        while (tx_gaps && $urandom_range(0, 99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    task automatic send_ch(input logic [7:0] c, input logic [COLUMN_BITS-1:0] col);
        t_in_beat b;
        b.ch    = c;
        b.col   = col;
        b.flush = 1'b0;
        send_beat(b);
    endtask

    task automatic send_flush(input logic [COLUMN_BITS-1:0] col);
        t_in_beat b;
        b.ch    = 8'($urandom);
        b.col   = col;
        b.flush = 1'b1;
        send_beat(b);
    endtask

    task automatic send_text(input string s, input logic [COLUMN_BITS-1:0] col0);
        for (int j = 0; j < s.len(); j++) begin
            send_ch(s[j], col0 + COLUMN_BITS'(j));
        end
    endtask

    task automatic send_run();
        int n;
        string s;
        n = $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0) begin
            col_cursor = $urandom_range(0, 1) ? 16'hFFFD : 16'($urandom);
        end
        repeat (n) begin
            s = spelling($urandom_range(0, SPELLING_COUNT - 1));
            send_text(s, col_cursor);
            col_cursor += COLUMN_BITS'(s.len());
        end
        case ($urandom_range(0, 3))
            0, 1: send_flush(col_cursor);
            2: send_ch(8'($urandom_range(32, 126)), col_cursor);
            default: ;
        endcase
        col_cursor += COLUMN_BITS'(1);
    endtask

    task automatic send_noise();
        t_in_beat b;
        b.ch    = 8'($urandom);
        b.col   = COLUMN_BITS'($urandom);
        b.flush = ($urandom_range(0, 7) == 0);
        send_beat(b);
    endtask

    // Waits until every expected token has come back, then lets the pipeline empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_digraphs(input logic enable);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= enable;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [5:0] digraph_plan;
        int goal;
        digraph_plan = 6'b101101;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_flush(16'd0);
        send_ch(8'h00, 16'd0);
        send_ch(8'hFF, 16'hFFFF);
        send_text("%:%x", 16'hFFFE);
        send_text("..", 16'hFFFF);
        send_flush(16'd1);
        send_text("...", 16'd5);
        send_text(".9", 16'd8);
        send_text("%:%:", 16'd10);
        send_text("%:", 16'd16);
        settle();
        write_digraphs(1'b0);
        send_text("%:", 16'd18);
        send_text("<:", 16'd20);
        send_flush(16'd22);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_digraphs(digraph_plan[ph]);
            tx_gaps = (ph != 2);
            rx_steady <= (ph == 2);
            if (ph == 3) begin
                hold_req <= hold_req + 1;
            end
            goal = beats_sent + PHASE_BEATS;
            while (beats_sent < goal) begin
                if ($urandom_range(0, 99) < 80) send_run();
                else send_noise();
            end
        end
        settle();

        if (fail_count == 0) begin
            $display("[c_punctuator_scanner_unit] OK");
        end else begin
            $display("[c_punctuator_scanner_unit] ERROR");
        end
        $finish;
    end

endmodule
